[rtl/accel_stillness_detector_core_macros.svh]
// Assertion macros used by the stillness detector checker.
`ifndef ACCEL_STILLNESS_DETECTOR_CORE_MACROS_SVH
`define ACCEL_STILLNESS_DETECTOR_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/asd_pkg.sv]
// Shared types, constants and helpers of the accelerometer stillness detector.
package asd_pkg;

    // Design constants
    localparam int HISTORY_DEPTH = 4;
    localparam int CHANNELS      = 3;
    localparam int ADC_BITS      = 10;

    // Fixed field widths
    localparam int NUM_LANES  = 3;
    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 18;
    localparam int ROUNDS_W   = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;
    localparam int ADC_USE    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;

    localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0]    TOL_RESET    = 18'd280;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 8'd192;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOLERANCE = 2'd0,
        REG_ROUNDS    = 2'd1
    } t_reg_idx;

    typedef logic [SUM_W-1:0]                   t_sum;
    typedef logic [NUM_LANES-1:0][SUM_W-1:0]    t_reading;
    typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] t_samples;

    // Accumulator status toward the top level
    typedef struct packed {
        logic     done;
        t_reading reading;
    } t_acc_status;

    // Keep the converter bits of a sample, zero-extended to sum width
    function automatic t_sum adc_value(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] m;
        m = s & SAMPLE_W'((1 << ADC_USE) - 1);
        return {{(SUM_W-SAMPLE_W){1'b0}}, m};
    endfunction

endpackage

[rtl/asd_accum.sv]
// Per-channel running sums and the round counter that closes a reading.
module asd_accum
    import asd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  t_samples            i_samples,
    input  logic [ROUNDS_W-1:0] i_rounds,
    output t_acc_status         o_status
);

    logic [ROUNDS_W-1:0] r_count;
    logic [ROUNDS_W-1:0] n_count;
    t_reading            r_sums;
    t_reading            n_sums;
    logic                w_done;

    // Reading closes when the count wraps or reaches the configured rounds
    assign n_count = r_count + ROUNDS_W'(1);
    assign w_done  = (n_count == '0) || (n_count >= i_rounds);

    // Saturating add per lane; lanes past CHANNELS stay zero
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_used
            logic [SUM_W:0] w_add;
            assign w_add     = {1'b0, r_sums[c]} + {1'b0, adc_value(i_samples[c])};
            assign n_sums[c] = w_add[SUM_W] ? SUM_MAX : w_add[SUM_W-1:0];
        end else begin : g_unused
            assign n_sums[c] = '0;
        end
    end

    assign o_status.done    = w_done;
    assign o_status.reading = n_sums;

    // Advance on every word; restart when a reading closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sums  <= '0;
        end else if (i_take) begin
            if (w_done) begin
                r_count <= '0;
                r_sums  <= '0;
            end else begin
                r_count <= n_count;
                r_sums  <= n_sums;
            end
        end
    end

endmodule

[rtl/asd_hist_cell.sv]
// One history entry: compares the new reading and shifts its entry onward.
module asd_hist_cell
    import asd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_shift,
    input  t_reading i_prev,
    input  t_reading i_reading,
    input  t_sum     i_tol,
    output t_reading o_entry,
    output logic     o_near
);

    t_reading               r_entry;
    logic [NUM_LANES-1:0]   w_lane_ok;

    // Absolute difference per lane against the tolerance
    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            t_sum d;
            d = (r_entry[c] > i_reading[c]) ? (r_entry[c] - i_reading[c])
                                            : (i_reading[c] - r_entry[c]);
            w_lane_ok[c] = (d <= i_tol);
        end
    end

    assign o_near  = &w_lane_ok;
    assign o_entry = r_entry;

    // Take the neighbor's entry when a reading closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_prev;
        end
    end

endmodule

[rtl/accel_stillness_detector_core.sv]
// Top level of the accelerometer stillness detector.
//
// Slave stream: one word per round of three ADC samples (x, y, z).
// Master stream: one word per completed reading, carrying the three sums
// and a still flag in tuser. Rounds that do not close a reading emit nothing.
// Config channel: index 0 sets the tolerance, index 1 the rounds per reading.
// Write only while the block is idle; o_cfg_ready is always high.
// Throughput: one input word per cycle while no closing round is held back
// by a stalled result. The accumulate, the compare across the chain of
// history cells and the shift all happen in the accepting cycle. A result
// reaches the output register in the cycle after its closing round is taken.
// Reset clears the sums, round count and history (all entries zero) and
// restores tolerance 280 and 192 rounds per reading.
// While the receiver stalls a pending result, rounds that do not close a
// reading are still taken; a closing round waits until the result drains.
module accel_stillness_detector_core
    import asd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SUM_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // sample_x, sample_y, sample_z, pad
    // Output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // sum_x, sum_y, sum_z, pad
    output logic [0:0]            o_m_tuser    // still
);

    t_sum                r_tol;
    logic [ROUNDS_W-1:0] r_rounds;
    logic                r_out_valid;
    t_reading            r_out_sums;
    logic                r_out_still;

    t_samples                 w_samples;
    t_acc_status              w_acc;
    logic                     w_take;
    logic                     w_shift;
    t_reading                 w_entry [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] w_near;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_rounds <= ROUNDS_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_TOLERANCE: r_tol    <= i_cfg_data;
                REG_ROUNDS:    r_rounds <= i_cfg_data[ROUNDS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Unpack samples
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_unpack
        assign w_samples[c] = i_s_tdata[c*SAMPLE_W +: SAMPLE_W];
    end

    // Hold closing words while a result waits
    assign o_s_tready = !r_out_valid || i_m_tready || !w_acc.done;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign w_shift    = w_take && w_acc.done;

    asd_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_samples (w_samples),
        .i_rounds  (r_rounds),
        .o_status  (w_acc)
    );

    // Chain of history cells; the newest reading enters at the head
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        t_reading w_prev;
        if (k == 0) begin : g_head
            assign w_prev = w_acc.reading;
        end else begin : g_body
            assign w_prev = w_entry[k-1];
        end

        asd_hist_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_shift),
            .i_prev    (w_prev),
            .i_reading (w_acc.reading),
            .i_tol     (r_tol),
            .o_entry   (w_entry[k]),
            .o_near    (w_near[k])
        );
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_shift) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_out_sums  <= w_acc.reading;
            r_out_still <= &w_near;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - NUM_LANES*SUM_W){1'b0}}, r_out_sums};
    assign o_m_tuser  = r_out_still;

endmodule

[rtl/asd_checker.sv]
// Port-level checker for the stillness detector, bound to the top level.
`include "accel_stillness_detector_core_macros.svh"

module asd_checker
    import asd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [0:0]            o_m_tuser
);

    // A stalled result word holds
    `ASD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)), "stalled result changed")

    // A new result only follows an accepted input word
    `ASD_ASSERT(a_out_cause, i_clk, i_rst_n, (o_m_tvalid && !$past(o_m_tvalid && !i_m_tready)) |-> $past(i_s_tvalid && o_s_tready), "result without input")

    // Reset empties the output register
    `ASD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // Input is always taken while the output side is free
    `ASD_ASSERT(a_in_free, i_clk, i_rst_n, !o_m_tvalid |-> (o_s_tready && o_cfg_ready), "input blocked while idle")

    // Register writes are to land only while no result word waits; the block does not enforce this
    `ASD_ASSERT(a_cfg_idle, i_clk, i_rst_n, (i_cfg_valid && o_cfg_ready) |-> !o_m_tvalid, "config write with a result pending")

endmodule

bind accel_stillness_detector_core asd_checker u_asd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
